// ===== design/dspg_pkg.sv =====
// Shared types and constants of the dual step pulse generator.
`timescale 1ns / 1ps

package dspg_pkg;

  // Widths fixed by the item fields and the timer state.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SEL_W    = 2;
  localparam int unsigned RATE_W   = 20;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned PERIOD_W = 16;

  // Timer reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd999;
  localparam logic [PERIOD_W-1:0] COMPARE_RESET = 16'd500;

  // Request op codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Channel selector codes; the last one selects no channel.
  localparam logic [SEL_W-1:0] SEL_ONE  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_TWO  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BOTH = 2'd2;
  localparam logic [SEL_W-1:0] SEL_NONE = 2'd3;

  // Commands handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2,
    CMD_HALT  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                sel_two;
    logic                sel_one;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] compare;
  } cmd_t;

endpackage

// ===== design/dspg_if.sv =====
// Request and result channel interfaces of the dual step pulse generator.
`timescale 1ns / 1ps

interface dspg_in_if;
  logic                               valid;
  logic                               ready;
  logic [dspg_pkg::OP_W-1:0]          op;
  logic [dspg_pkg::SEL_W-1:0]         channel_select;
  logic [dspg_pkg::RATE_W-1:0]        step_rate;
  logic [dspg_pkg::TOTAL_W-1:0]       step_total;

  modport source (output valid, output op, output channel_select, output step_rate,
                  output step_total, input ready);
  modport sink   (input valid, input op, input channel_select, input step_rate,
                  input step_total, output ready);
endinterface

interface dspg_out_if;
  logic valid;
  logic ready;
  logic step_one;
  logic step_two;
  logic busy_one;
  logic busy_two;
  logic any_busy;

  modport source (output valid, output step_one, output step_two, output busy_one,
                  output busy_two, output any_busy, input ready);
  modport sink   (input valid, input step_one, input step_two, input busy_one,
                  input busy_two, input any_busy, output ready);
endinterface

// ===== design/dspg_front.sv =====
// Front end: accepts requests, decodes them and works out period and compare for starts.
`timescale 1ns / 1ps

module dspg_front #(
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned STEP_COUNT_WIDTH = 32,
  parameter int unsigned PERIOD_MAX       = 65535
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dspg_in_if.sink                     in_ch,
  input  logic                        q_full,
  output logic                        q_push,
  output dspg_pkg::cmd_t              q_cmd,
  output logic [STEP_COUNT_WIDTH-1:0] q_steps
);

  localparam int unsigned DIV_W = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned RW    = dspg_pkg::RATE_W;

  typedef enum logic [2:0] {
    FR_IDLE = 3'b001,
    FR_DIV  = 3'b010,
    FR_EMIT = 3'b100
  } fr_state_t;

  fr_state_t                   state_r, state_nxt;
  logic [RW-1:0]               div_r, div_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [DIV_W-1:0]            dq_r, dq_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                        sel_one_r, sel_one_nxt;
  logic                        sel_two_r, sel_two_nxt;
  logic [STEP_COUNT_WIDTH-1:0] steps_r, steps_nxt;

  logic                        accept;
  logic [STEP_COUNT_WIDTH-1:0] in_steps;
  logic                        in_sel_one, in_sel_two;
  logic                        start_run;
  logic [RW:0]                 rem_sh;
  logic [RW:0]                 rem_diff;
  logic [DIV_W-1:0]            per_m1;
  logic                        per_sat;
  logic [dspg_pkg::PERIOD_W-1:0] period_w;
  logic [dspg_pkg::PERIOD_W-1:0] half_w;
  logic [dspg_pkg::PERIOD_W-1:0] compare_w;

  assign in_ch.ready = (state_r == FR_IDLE) && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_steps    = in_ch.step_total[STEP_COUNT_WIDTH-1:0];
  assign in_sel_one  = (in_ch.channel_select == dspg_pkg::SEL_ONE) ||
                       (in_ch.channel_select == dspg_pkg::SEL_BOTH);
  assign in_sel_two  = (in_ch.channel_select == dspg_pkg::SEL_TWO) ||
                       (in_ch.channel_select == dspg_pkg::SEL_BOTH);
  assign start_run   = (dspg_pkg::op_t'(in_ch.op) == dspg_pkg::OP_START) && (in_steps != '0);

  // One restoring division step: shift in the next dividend bit, subtract if it fits
  assign rem_sh   = {rem_r, dq_r[DIV_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};

  // Turn the quotient into period and compare
  assign per_m1    = (dq_r > DIV_W'(1)) ? (dq_r - DIV_W'(1)) : DIV_W'(1);
  assign per_sat   = 32'(per_m1) > 32'(PERIOD_MAX);
  assign period_w  = per_sat ? dspg_pkg::PERIOD_W'(PERIOD_MAX) : dspg_pkg::PERIOD_W'(per_m1);
  assign half_w    = period_w >> 1;
  assign compare_w = (half_w == '0) ? dspg_pkg::PERIOD_W'(1) : half_w;

  always_comb begin
    state_nxt     = state_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    sel_one_nxt   = sel_one_r;
    sel_two_nxt   = sel_two_r;
    steps_nxt     = steps_r;
    q_push        = 1'b0;
    q_cmd.kind    = dspg_pkg::CMD_NOP;
    q_cmd.sel_one = in_sel_one;
    q_cmd.sel_two = in_sel_two;
    q_cmd.period  = period_w;
    q_cmd.compare = compare_w;
    q_steps       = in_steps;
    unique case (state_r)
      FR_IDLE: begin
        if (accept) begin
          if (start_run) begin
            // Hold the start and begin the divide
            div_nxt     = (in_ch.step_rate == '0) ? RW'(1) : in_ch.step_rate;
            rem_nxt     = '0;
            dq_nxt      = DIV_W'(TICKS_PER_SECOND);
            cnt_nxt     = CNT_W'(DIV_W);
            sel_one_nxt = in_sel_one;
            sel_two_nxt = in_sel_two;
            steps_nxt   = in_steps;
            state_nxt   = FR_DIV;
          end else begin
            // Pass everything else straight on
            q_push = 1'b1;
            priority case (dspg_pkg::op_t'(in_ch.op))
              dspg_pkg::OP_TICK:  q_cmd.kind = dspg_pkg::CMD_TICK;
              dspg_pkg::OP_START: q_cmd.kind = dspg_pkg::CMD_HALT;
              dspg_pkg::OP_STOP:  q_cmd.kind = dspg_pkg::CMD_HALT;
              default:            q_cmd.kind = dspg_pkg::CMD_NOP;
            endcase
          end
        end
      end
      FR_DIV: begin
        if (!rem_diff[RW]) begin
          rem_nxt = rem_diff[RW-1:0];
          dq_nxt  = {dq_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[RW-1:0];
          dq_nxt  = {dq_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = FR_EMIT;
        end
      end
      FR_EMIT: begin
        // Push the start once the queue has room
        q_cmd.kind    = dspg_pkg::CMD_START;
        q_cmd.sel_one = sel_one_r;
        q_cmd.sel_two = sel_two_r;
        q_steps       = steps_r;
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = FR_IDLE;
        end
      end
      default: state_nxt = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r     <= div_nxt;
    rem_r     <= rem_nxt;
    dq_r      <= dq_nxt;
    cnt_r     <= cnt_nxt;
    sel_one_r <= sel_one_nxt;
    sel_two_r <= sel_two_nxt;
    steps_r   <= steps_nxt;
  end

  // Partial remainder stays below the divisor through the divide
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_DIV) |-> (rem_r < div_r))
    else $error("front: partial remainder not below divisor");

  // Never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front: push while queue full");

  // A start that enters the divide loads the step counter with the quotient width
  a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FR_IDLE && state_nxt == FR_DIV) |=> (cnt_r == CNT_W'(DIV_W)))
    else $error("front: divide step count not loaded");

endmodule

// ===== design/dspg_queue.sv =====
// Short command queue between the front and the back.
`timescale 1ns / 1ps

module dspg_queue #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full     = (fill_r == CNT_W'(DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/dspg_back.sv =====
// Back end: runs the shared tick counter and both step channels, and registers the result.
`timescale 1ns / 1ps

module dspg_back #(
  parameter int unsigned STEP_COUNT_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  dspg_pkg::cmd_t              q_cmd,
  input  logic [STEP_COUNT_WIDTH-1:0] q_steps,
  output logic                        q_pop,
  dspg_out_if.source                  out_ch
);

  localparam int unsigned PW = dspg_pkg::PERIOD_W;

  logic [PW-1:0]               cnt_r, cnt_nxt;
  logic [PW-1:0]               per_act_r, per_act_nxt;
  logic [PW-1:0]               per_sh_r, per_sh_nxt;
  logic [PW-1:0]               cmp_act_r, cmp_act_nxt;
  logic [PW-1:0]               cmp_sh_r, cmp_sh_nxt;
  logic [STEP_COUNT_WIDTH-1:0] rem_r [2];
  logic [STEP_COUNT_WIDTH-1:0] rem_nxt [2];
  logic [1:0]                  busy_r, busy_nxt;
  logic [1:0]                  sel;

  logic out_valid_r;
  logic step_one_r, step_two_r, busy_one_r, busy_two_r, any_busy_r;

  assign q_pop = !q_empty && (!out_valid_r || out_ch.ready);
  assign sel   = {q_cmd.sel_two, q_cmd.sel_one};

  // Work out the state after the command at the queue head; an empty queue reads as a no-op
  always_comb begin
    cnt_nxt     = cnt_r;
    per_act_nxt = per_act_r;
    per_sh_nxt  = per_sh_r;
    cmp_act_nxt = cmp_act_r;
    cmp_sh_nxt  = cmp_sh_r;
    rem_nxt     = rem_r;
    busy_nxt    = busy_r;
    unique case (q_empty ? dspg_pkg::CMD_NOP : q_cmd.kind)
      dspg_pkg::CMD_TICK: begin
        if (busy_r != 2'b00) begin
          if (cnt_r >= per_act_r) begin
            // Wrap: load shadows and count down busy channels
            cnt_nxt     = '0;
            per_act_nxt = per_sh_r;
            cmp_act_nxt = cmp_sh_r;
            for (int ch = 0; ch < 2; ch++) begin
              if (busy_r[ch]) begin
                if (rem_r[ch] != '0) begin
                  rem_nxt[ch] = rem_r[ch] - STEP_COUNT_WIDTH'(1);
                end
                if (rem_r[ch] <= STEP_COUNT_WIDTH'(1)) begin
                  busy_nxt[ch] = 1'b0;
                end
              end
            end
          end else begin
            cnt_nxt = cnt_r + PW'(1);
          end
        end
      end
      dspg_pkg::CMD_START: begin
        per_sh_nxt = q_cmd.period;
        cmp_sh_nxt = q_cmd.compare;
        for (int ch = 0; ch < 2; ch++) begin
          if (sel[ch]) begin
            rem_nxt[ch]  = q_steps;
            busy_nxt[ch] = 1'b1;
          end
        end
      end
      dspg_pkg::CMD_HALT: begin
        for (int ch = 0; ch < 2; ch++) begin
          if (sel[ch]) begin
            rem_nxt[ch]  = '0;
            busy_nxt[ch] = 1'b0;
          end
        end
      end
      dspg_pkg::CMD_NOP: begin
      end
    endcase
  end

  // Commit state on a pop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      per_act_r <= dspg_pkg::PERIOD_RESET;
      per_sh_r  <= dspg_pkg::PERIOD_RESET;
      cmp_act_r <= dspg_pkg::COMPARE_RESET;
      cmp_sh_r  <= dspg_pkg::COMPARE_RESET;
      rem_r[0]  <= '0;
      rem_r[1]  <= '0;
      busy_r    <= 2'b00;
    end else if (q_pop) begin
      cnt_r     <= cnt_nxt;
      per_act_r <= per_act_nxt;
      per_sh_r  <= per_sh_nxt;
      cmp_act_r <= cmp_act_nxt;
      cmp_sh_r  <= cmp_sh_nxt;
      rem_r     <= rem_nxt;
      busy_r    <= busy_nxt;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      step_one_r <= busy_nxt[0] && (cnt_nxt < cmp_act_nxt);
      step_two_r <= busy_nxt[1] && (cnt_nxt < cmp_act_nxt);
      busy_one_r <= busy_nxt[0];
      busy_two_r <= busy_nxt[1];
      any_busy_r <= busy_nxt[0] || busy_nxt[1];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.step_one = step_one_r;
  assign out_ch.step_two = step_two_r;
  assign out_ch.busy_one = busy_one_r;
  assign out_ch.busy_two = busy_two_r;
  assign out_ch.any_busy = any_busy_r;

  // Counter never runs past the active period
  a_cnt_in_period: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= per_act_r)
    else $error("back: tick counter past active period");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !q_pop)
    else $error("back: pop while result stalled");

  // A step level only shows on a busy channel
  a_step_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!(step_one_r && !busy_one_r) && !(step_two_r && !busy_two_r)))
    else $error("back: step high on idle channel");

endmodule

// ===== design/dual_step_pulse_generator.sv =====
// Top level of the dual step pulse generator.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-------------------------------------------
//   in_ch    | sink      | valid/ready          | op, channel_select, step_rate, step_total
//   out_ch   | source    | valid/ready          | step_one, step_two, busy_one, busy_two, any_busy
//
// The front takes ticks, stops and other requests one per cycle while the queue has room.
// A start with a nonzero step count runs the bit-serial period divider in the front end,
// which takes no new request until the start is pushed.
// The back end retires one queued command per cycle to the result register unless stalled.
// Reset is synchronous, active low, and restores the timer reset values.
// A stalled result holds the back end; the queue lets the front keep taking requests.
`timescale 1ns / 1ps

module dual_step_pulse_generator #(
  parameter int unsigned TICKS_PER_SECOND = 1000000,
  parameter int unsigned STEP_COUNT_WIDTH = 32,
  parameter int unsigned PERIOD_MAX       = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  dspg_in_if.sink    in_ch,
  dspg_out_if.source out_ch
);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CMD_W       = $bits(dspg_pkg::cmd_t);
  localparam int unsigned QW          = CMD_W + STEP_COUNT_WIDTH;

  logic                        q_push, q_pop, q_full, q_empty;
  dspg_pkg::cmd_t              push_cmd, pop_cmd;
  logic [STEP_COUNT_WIDTH-1:0] push_steps, pop_steps;
  logic [QW-1:0]               push_data, pop_data;

  assign push_data = {push_cmd, push_steps};
  assign pop_cmd   = dspg_pkg::cmd_t'(pop_data[QW-1:STEP_COUNT_WIDTH]);
  assign pop_steps = pop_data[STEP_COUNT_WIDTH-1:0];

  dspg_front #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH),
    .PERIOD_MAX       (PERIOD_MAX)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd),
    .q_steps (push_steps)
  );

  dspg_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  dspg_back #(
    .STEP_COUNT_WIDTH (STEP_COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (pop_cmd),
    .q_steps (pop_steps),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/dual_step_pulse_generator_tb.sv =====
// Self-checking testbench of the dual step pulse generator: predicted pin levels vs. results.
`timescale 1ns / 1ps

module dual_step_pulse_generator_tb;

  localparam int unsigned TICKS_PER_SECOND = 1000000;
  localparam int unsigned PERIOD_MAX       = 65535;
  localparam int unsigned RANDOM_ITEMS     = 180;
  localparam int unsigned HOLD_AFTER       = 60;
  localparam int unsigned HOLD_CYCLES      = 500;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned FAST_RATE_MIN    = 50000;
  localparam int unsigned PW               = dspg_pkg::PERIOD_W;
  localparam int unsigned SW               = dspg_pkg::SEL_W;
  localparam int unsigned RW               = dspg_pkg::RATE_W;
  localparam int unsigned TW               = dspg_pkg::TOTAL_W;

  // Tracks timer and channel state, and holds the pin levels still owed by the block.
  class pulse_model;
    logic [PW-1:0] counter;
    logic [PW-1:0] period_act;
    logic [PW-1:0] period_sh;
    logic [PW-1:0] cmp_act;
    logic [PW-1:0] cmp_sh;
    logic [TW-1:0] remaining [2];
    bit            busy [2];
    logic [4:0]    owed_levels [$];
    int unsigned   errors;

    function new();
      counter    = '0;
      period_act = dspg_pkg::PERIOD_RESET;
      period_sh  = dspg_pkg::PERIOD_RESET;
      cmp_act    = dspg_pkg::COMPARE_RESET;
      cmp_sh     = dspg_pkg::COMPARE_RESET;
      remaining  = '{default: '0};
      busy       = '{default: 1'b0};
      errors     = 0;
    endfunction

    function bit picks(logic [SW-1:0] sel, int ch);
      return (sel == dspg_pkg::SEL_BOTH) ||
             (ch == 0 ? sel == dspg_pkg::SEL_ONE : sel == dspg_pkg::SEL_TWO);
    endfunction

    function void halt(logic [SW-1:0] sel);
      for (int ch = 0; ch < 2; ch++) begin
        if (picks(sel, ch)) begin
          remaining[ch] = '0;
          busy[ch]      = 1'b0;
        end
      end
    endfunction

    // Load shadows and count down the busy channels.
    function void wrap();
      period_act = period_sh;
      cmp_act    = cmp_sh;
      for (int ch = 0; ch < 2; ch++) begin
        if (busy[ch]) begin
          if (remaining[ch] != '0) remaining[ch] = remaining[ch] - 1'b1;
          if (remaining[ch] == '0) busy[ch] = 1'b0;
        end
      end
    endfunction

    function void note_request(dspg_pkg::op_t op, logic [SW-1:0] sel, logic [RW-1:0] rate,
                               logic [TW-1:0] total);
      int unsigned r;
      int unsigned q;
      bit          below;
      case (op)
        dspg_pkg::OP_TICK: begin
          if (busy[0] || busy[1]) begin
            if (counter >= period_act) begin
              counter = '0;
              wrap();
            end else begin
              counter = counter + 1'b1;
            end
          end
        end
        dspg_pkg::OP_START: begin
          if (total == '0) begin
            halt(sel);
          end else begin
            r = (rate == '0) ? 1 : rate;
            q = TICKS_PER_SECOND / r;
            q = (q > 1) ? q - 1 : 1;
            if (q > PERIOD_MAX) q = PERIOD_MAX;
            period_sh = PW'(q);
            cmp_sh    = (q / 2 < 1) ? PW'(1) : PW'(q / 2);
            for (int ch = 0; ch < 2; ch++) begin
              if (picks(sel, ch)) begin
                remaining[ch] = total;
                busy[ch]      = 1'b1;
              end
            end
          end
        end
        dspg_pkg::OP_STOP: halt(sel);
        default: ;
      endcase
      below = counter < cmp_act;
      owed_levels.push_back({busy[0] & below, busy[1] & below, busy[0], busy[1],
                             busy[0] | busy[1]});
    endfunction

    function void check_levels(logic [4:0] got);
      string      field_name [5];
      logic [4:0] want;
      field_name = '{"any_busy", "busy_two", "busy_one", "step_two", "step_one"};
      if (owed_levels.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none actual %b", $time, got);
        errors++;
        return;
      end
      want = owed_levels.pop_front();
      for (int i = 0; i < 5; i++) begin
        if (want[i] !== got[i]) begin
          $display("%0t ERROR %s mismatch: expected %b actual %b", $time, field_name[i],
                   want[i], got[i]);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return owed_levels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  dspg_in_if   in_if ();
  dspg_out_if  out_if ();
  pulse_model  model = new();
  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  dual_step_pulse_generator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watch both handshakes and feed the model.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready)
        model.note_request(dspg_pkg::op_t'(in_if.op), in_if.channel_select,
                           in_if.step_rate, in_if.step_total);
      if (out_if.valid && out_if.ready)
        model.check_levels({out_if.step_one, out_if.step_two, out_if.busy_one,
                            out_if.busy_two, out_if.any_busy});
    end
  end

  // Bound the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side on a shifting duty pattern, with one long hold-off.
  initial begin
    int unsigned pct;
    int unsigned mode_left;
    out_if.ready = 1'b0;
    forever begin
      case ($urandom_range(0, 3))
        0:       pct = 100;
        1:       pct = 80;
        2:       pct = 50;
        default: pct = 15;
      endcase
      mode_left = $urandom_range(5, 60);
      repeat (mode_left) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          out_if.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end else begin
          out_if.ready <= rst_n && ($urandom_range(1, 100) <= pct);
        end
      end
    end
  end

  // Offer one request in bursts with random gaps; return once it is taken.
  task automatic send_req(input dspg_pkg::op_t op, input logic [SW-1:0] sel,
                          input logic [RW-1:0] rate, input logic [TW-1:0] total);
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200) :
                                                  $urandom_range(1, 30);
    end
    in_if.valid          <= 1'b1;
    in_if.op             <= op;
    in_if.channel_select <= sel;
    in_if.step_rate      <= rate;
    in_if.step_total     <= total;
    do @(posedge clk); while (!in_if.ready);
    burst_left--;
    sent_count++;
  endtask

  function automatic logic [RW-1:0] fast_rate();
    return RW'($urandom_range(FAST_RATE_MIN, TICKS_PER_SECOND));
  endfunction

  function automatic logic [TW-1:0] pick_total();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2:    return $urandom;
      default: return TW'($urandom_range(1, 6));
    endcase
  endfunction

  // Tick with random don't-care fields.
  task automatic send_tick();
    send_req(dspg_pkg::OP_TICK, SW'($urandom), RW'($urandom_range(0, TICKS_PER_SECOND)),
             $urandom);
  endtask

  // Main stimulus.
  initial begin
    int unsigned run_start;
    int unsigned pick;
    in_if.valid          = 1'b0;
    in_if.op             = dspg_pkg::OP_TICK;
    in_if.channel_select = dspg_pkg::SEL_ONE;
    in_if.step_rate      = '0;
    in_if.step_total     = '0;
    rst_n                = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: idle tick, field extremes, odd selectors and op codes, saturation.
    send_req(dspg_pkg::OP_TICK, dspg_pkg::SEL_ONE, '0, '0);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_ONE, '0, 32'd3);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_NONE, 20'd1, 32'd1);
    send_req(dspg_pkg::OP_NONE, dspg_pkg::SEL_BOTH, 20'd1000000, 32'hFFFF_FFFF);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_TWO, 20'd1000000, 32'hFFFF_FFFF);
    send_tick();
    send_tick();
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_ONE, 20'd500, '0);
    send_req(dspg_pkg::OP_STOP, dspg_pkg::SEL_NONE, '0, '0);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_BOTH, 20'd15, 32'd7);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_BOTH, 20'd16, 32'd7);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_ONE, 20'd999999, 32'd2);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_TWO, 20'd500000, 32'd2);
    send_tick();
    send_req(dspg_pkg::OP_STOP, dspg_pkg::SEL_ONE, '0, '0);
    send_req(dspg_pkg::OP_STOP, dspg_pkg::SEL_BOTH, '0, '0);
    send_tick();
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_BOTH, 20'd333333, 32'd4);
    send_req(dspg_pkg::OP_START, dspg_pkg::SEL_BOTH, 20'd250000, 32'd5000);

    // Run the reset period out so the fast shadow values take over.
    repeat (1001) send_tick();
    send_req(dspg_pkg::OP_STOP, dspg_pkg::SEL_BOTH, '0, '0);

    // Random: mostly starts followed by tick runs, with stops and noise.
    run_start = sent_count;
    while (sent_count < run_start + RANDOM_ITEMS) begin
      if (sent_count >= run_start + HOLD_AFTER) hold_req = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 30)) send_tick();
      end else if (pick < 80) begin
        send_req(dspg_pkg::OP_START, SW'($urandom_range(0, 3)), fast_rate(), pick_total());
      end else if (pick < 88) begin
        send_req(dspg_pkg::OP_STOP, SW'($urandom_range(0, 3)), RW'($urandom), $urandom);
      end else if (pick < 92) begin
        send_req(dspg_pkg::OP_NONE, SW'($urandom), RW'($urandom), $urandom);
      end else begin
        // Slow rate, overwritten by a fast one before any wrap can load it.
        send_req(dspg_pkg::OP_START, SW'($urandom_range(0, 3)),
                 RW'($urandom_range(0, FAST_RATE_MIN - 1)), pick_total());
        send_req(dspg_pkg::OP_START, SW'($urandom_range(0, 3)), fast_rate(),
                 TW'($urandom_range(1, 6)));
      end
    end
    in_if.valid <= 1'b0;

    // Drain the outstanding results, then watch for strays.
    while (model.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dspg_pkg.sv
design/dspg_if.sv
design/dspg_front.sv
design/dspg_queue.sv
design/dspg_back.sv
design/dual_step_pulse_generator.sv
tb/dual_step_pulse_generator_tb.sv
